// File: sv/tlp_pkg.sv
// Package for the traffic light controller with pedestrian walk light.
// Holds the item types, the phase enum, register indexes and the phase tables.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tlp_pkg;

  localparam int unsigned DWELL_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = DWELL_W;

  localparam logic [DWELL_W-1:0] LONG_DWELL_RESET  = 16'd200;
  localparam logic [DWELL_W-1:0] SHORT_DWELL_RESET = 16'd50;

  localparam logic [CFG_IDX_W-1:0] REG_LONG_DWELL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_DWELL = 2'd1;

  // Lamp patterns: east/west red,yellow,green in bits 5..3, north/south in bits 2..0.
  localparam logic [5:0] ROAD_BOTH_RED = 6'h24;
  localparam logic [5:0] ROAD_GO_EW    = 6'h0C;
  localparam logic [5:0] ROAD_GO_NS    = 6'h21;
  localparam logic [5:0] ROAD_YEL_EW   = 6'h14;
  localparam logic [5:0] ROAD_YEL_NS   = 6'h22;
  localparam logic [5:0] ROAD_OFF      = 6'h00;

  localparam logic [1:0] WALK_GREEN = 2'b10;
  localparam logic [1:0] WALK_RED   = 2'b01;
  localparam logic [1:0] WALK_OFF   = 2'b00;

  typedef enum logic [3:0] {
    PH_WALK    = 4'd0,
    PH_FLASH1  = 4'd1,
    PH_FLASH2  = 4'd2,
    PH_FLASH3  = 4'd3,
    PH_FLASH4  = 4'd4,
    PH_FLASH5  = 4'd5,
    PH_GO_EW   = 4'd6,
    PH_GO_NS   = 4'd7,
    PH_YEL_EW  = 4'd8,
    PH_YEL_NS  = 4'd9
  } phase_e;

  typedef struct packed {
    logic ew_car;
    logic ns_car;
    logic pedestrian;
  } in_item_t;

  typedef struct packed {
    logic [5:0] road_lamps;
    logic [1:0] walk_lamps;
    logic [3:0] phase;
  } out_item_t;

  typedef struct packed {
    logic [DWELL_W-1:0] long_dwell;
    logic [DWELL_W-1:0] short_dwell;
  } dwell_cfg_t;

  function automatic logic [5:0] road_pattern(input phase_e ph);
    logic [5:0] pat;
    unique case (ph)
      PH_WALK, PH_FLASH1, PH_FLASH2,
      PH_FLASH3, PH_FLASH4, PH_FLASH5: pat = ROAD_BOTH_RED;
      PH_GO_EW:  pat = ROAD_GO_EW;
      PH_GO_NS:  pat = ROAD_GO_NS;
      PH_YEL_EW: pat = ROAD_YEL_EW;
      PH_YEL_NS: pat = ROAD_YEL_NS;
      default:   pat = ROAD_OFF;
    endcase
    return pat;
  endfunction

  function automatic logic [1:0] walk_pattern(input phase_e ph);
    logic [1:0] pat;
    unique case (ph)
      PH_WALK:                        pat = WALK_GREEN;
      PH_FLASH1, PH_FLASH3, PH_FLASH5: pat = WALK_OFF;
      PH_FLASH2, PH_FLASH4,
      PH_GO_EW, PH_GO_NS,
      PH_YEL_EW, PH_YEL_NS:           pat = WALK_RED;
      default:                        pat = WALK_OFF;
    endcase
    return pat;
  endfunction

  function automatic logic uses_long(input phase_e ph);
    return (ph == PH_WALK) || (ph == PH_GO_EW) || (ph == PH_GO_NS);
  endfunction

  // sel is pedestrian | ns_car<<1 | ew_car<<2.
  function automatic phase_e next_phase(input phase_e ph, input logic [2:0] sel);
    phase_e nx;
    unique case (ph)
      PH_WALK:   nx = (sel[2:1] == 2'b00) ? PH_WALK : PH_FLASH1;
      PH_FLASH1: nx = PH_FLASH2;
      PH_FLASH2: nx = PH_FLASH3;
      PH_FLASH3: nx = PH_FLASH4;
      PH_FLASH4: nx = PH_FLASH5;
      PH_FLASH5: nx = sel[2] ? PH_GO_EW : (sel[1] ? PH_GO_NS : PH_WALK);
      PH_GO_EW:  nx = (sel == 3'd4) ? PH_GO_EW : PH_YEL_EW;
      PH_GO_NS:  nx = (sel == 3'd2) ? PH_GO_NS : PH_YEL_NS;
      PH_YEL_EW: begin
        unique case (sel)
          3'd0, 3'd1, 3'd5: nx = PH_WALK;
          3'd4:             nx = PH_GO_EW;
          default:          nx = PH_GO_NS;
        endcase
      end
      PH_YEL_NS: begin
        unique case (sel)
          3'd2:       nx = PH_GO_NS;
          3'd4, 3'd6: nx = PH_GO_EW;
          default:    nx = PH_WALK;
        endcase
      end
      default:   nx = PH_WALK;
    endcase
    return nx;
  endfunction

endpackage

`default_nettype wire

// File: sv/traffic_light_pedestrian_fsm.sv
// Moore traffic light controller for a two-road crossing with a pedestrian walk light.
// Each input transfer is one 10 ms tick with the three detector bits; each tick gives one
// result transfer with the lamp patterns and the phase in force during that tick. A tick
// can be accepted in every clock cycle while results are taken; from the input register it
// passes the phase logic into the result register once that register is empty or being
// emptied, and its result is then shown on the outputs until it is taken.
// Dwell registers (index 0 long, index 1 short) take effect at the next phase reload.
// Depends on tlp_pkg, tlp_cfg_regs, tlp_in_stage and tlp_core.
`timescale 1ns / 1ps
`default_nettype none

module traffic_light_pedestrian_fsm (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire tlp_pkg::in_item_t              in_item,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output tlp_pkg::out_item_t                  out_item,
  input  wire logic                           cfg_we,
  input  wire logic [tlp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tlp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tlp_pkg::*;

  dwell_cfg_t dwell_cfg;
  logic       item_valid;
  in_item_t   item;
  logic       item_take;

  tlp_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .dwell_cfg (dwell_cfg)
  );

  tlp_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  tlp_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .dwell_cfg  (dwell_cfg),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

endmodule

`default_nettype wire

// File: sv/tlp_cfg_regs.sv
// Dwell configuration registers of the traffic light controller.
// Depends on tlp_pkg for the register indexes and reset values.
`timescale 1ns / 1ps
`default_nettype none

module tlp_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [tlp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tlp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output tlp_pkg::dwell_cfg_t                dwell_cfg
);
  import tlp_pkg::*;

  logic [DWELL_W-1:0] long_dwell_r, long_dwell_nxt;
  logic [DWELL_W-1:0] short_dwell_r, short_dwell_nxt;

  always_comb begin
    long_dwell_nxt  = long_dwell_r;
    short_dwell_nxt = short_dwell_r;
    if (cfg_we) begin
      // Writes to an index beyond the register list are dropped.
      unique case (cfg_index)
        REG_LONG_DWELL:  long_dwell_nxt  = cfg_wdata[DWELL_W-1:0];
        REG_SHORT_DWELL: short_dwell_nxt = cfg_wdata[DWELL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_dwell_r  <= LONG_DWELL_RESET;
      short_dwell_r <= SHORT_DWELL_RESET;
    end else begin
      long_dwell_r  <= long_dwell_nxt;
      short_dwell_r <= short_dwell_nxt;
    end
  end

  assign dwell_cfg.long_dwell  = long_dwell_r;
  assign dwell_cfg.short_dwell = short_dwell_r;

endmodule

`default_nettype wire

// File: sv/tlp_in_stage.sv
// Input register of the traffic light controller: holds one tick until the core takes it.
// Depends on tlp_pkg for the input item type.
`timescale 1ns / 1ps
`default_nettype none

module tlp_in_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire tlp_pkg::in_item_t in_item,
  output logic                   item_valid,
  output tlp_pkg::in_item_t      item,
  input  wire logic              item_take
);
  import tlp_pkg::*;

  logic     in_valid_r, in_valid_nxt;
  in_item_t in_item_r, in_item_nxt;
  logic     load;

  // The register is free when empty or when the core takes its tick this cycle.
  assign in_stall = in_valid_r && !item_take;
  assign load     = in_valid && !in_stall;

  always_comb begin
    in_item_nxt = load ? in_item : in_item_r;
    if (load) begin
      in_valid_nxt = 1'b1;
    end else if (item_take) begin
      in_valid_nxt = 1'b0;
    end else begin
      in_valid_nxt = in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_item_r <= in_item_nxt;
  end

  assign item_valid = in_valid_r;
  assign item       = in_item_r;

endmodule

`default_nettype wire

// File: sv/tlp_core.sv
// Phase state machine, dwell counter and result register of the traffic light controller.
// Depends on tlp_pkg for the phase enum, the phase tables and the item types.
`timescale 1ns / 1ps
`default_nettype none

module tlp_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire tlp_pkg::dwell_cfg_t dwell_cfg,
  input  wire logic                item_valid,
  input  wire tlp_pkg::in_item_t   item,
  output logic                     item_take,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output tlp_pkg::out_item_t       out_item
);
  import tlp_pkg::*;

  phase_e             phase_r, phase_nxt;
  logic [DWELL_W-1:0] ticks_left_r, ticks_left_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r, out_item_nxt;
  logic [2:0]         sel;
  phase_e             next_ph;
  logic               dwell_done;

  // A tick moves on whenever the result register is empty or being emptied.
  assign item_take = item_valid && (!out_valid_r || !out_stall);

  assign sel        = {item.ew_car, item.ns_car, item.pedestrian};
  assign next_ph    = next_phase(phase_r, sel);
  assign dwell_done = (ticks_left_r <= {{(DWELL_W-1){1'b0}}, 1'b1});

  always_comb begin
    phase_nxt      = phase_r;
    ticks_left_nxt = ticks_left_r;
    out_item_nxt   = out_item_r;
    out_valid_nxt  = item_take || (out_valid_r && out_stall);
    if (item_take) begin
      // Moore outputs: the lamps shown are those of the phase in force at the tick.
      out_item_nxt.road_lamps = road_pattern(phase_r);
      out_item_nxt.walk_lamps = walk_pattern(phase_r);
      out_item_nxt.phase      = phase_r;
      if (dwell_done) begin
        phase_nxt      = next_ph;
        ticks_left_nxt = uses_long(next_ph) ? dwell_cfg.long_dwell : dwell_cfg.short_dwell;
      end else begin
        ticks_left_nxt = ticks_left_r - {{(DWELL_W-1){1'b0}}, 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_WALK;
      ticks_left_r <= LONG_DWELL_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      ticks_left_r <= ticks_left_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_hold_phase: assert property (@(posedge clk) disable iff (!rst_n)
    item_take && !dwell_done |=> phase_r == $past(phase_r))
    else $error("phase changed before its dwell ran out");

  a_result_phase: assert property (@(posedge clk) disable iff (!rst_n)
    item_take |=> out_item_r.phase == $past(phase_r))
    else $error("result does not show the phase in force at its tick");

  a_reload: assert property (@(posedge clk) disable iff (!rst_n)
    item_take && dwell_done |=>
      ticks_left_r == (uses_long(phase_r) ? $past(dwell_cfg.long_dwell)
                                          : $past(dwell_cfg.short_dwell)))
    else $error("dwell not reloaded for the new phase");

  a_idle_state: assert property (@(posedge clk) disable iff (!rst_n)
    !item_take |=> $stable(phase_r) && $stable(ticks_left_r))
    else $error("state moved without a tick");

endmodule

`default_nettype wire

// File: test/tb_traffic_light_pedestrian_fsm.sv
// Testbench for traffic_light_pedestrian_fsm: random detector ticks and dwell settings,
// with each result checked against a predictor of the phase sequence and lamp patterns.
// Depends on tlp_pkg and the traffic_light_pedestrian_fsm RTL.
`timescale 1ns / 1ps

module tb_traffic_light_pedestrian_fsm;
  import tlp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
  localparam int unsigned DRAIN_SLACK = 4;

  // Tracks the crossing's phase and dwell count and holds the lamp patterns still due.
  class phase_scoreboard;
    logic [DWELL_W-1:0] long_dwell  = LONG_DWELL_RESET;
    logic [DWELL_W-1:0] short_dwell = SHORT_DWELL_RESET;
    phase_e             cur_phase   = PH_WALK;
    logic [DWELL_W-1:0] ticks_left  = LONG_DWELL_RESET;
    out_item_t          lamps_due[$];
    int unsigned        mismatches  = 0;

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_LONG_DWELL) begin
        long_dwell = data;
      end else if (idx == REG_SHORT_DWELL) begin
        short_dwell = data;
      end
    endfunction

    function out_item_t lamps_for(phase_e ph);
      out_item_t o;
      o.phase = ph;
      case (ph)
        PH_WALK: begin
          o.road_lamps = ROAD_BOTH_RED;
          o.walk_lamps = WALK_GREEN;
        end
        PH_FLASH1, PH_FLASH3, PH_FLASH5: begin
          o.road_lamps = ROAD_BOTH_RED;
          o.walk_lamps = WALK_OFF;
        end
        PH_FLASH2, PH_FLASH4: begin
          o.road_lamps = ROAD_BOTH_RED;
          o.walk_lamps = WALK_RED;
        end
        PH_GO_EW: begin
          o.road_lamps = ROAD_GO_EW;
          o.walk_lamps = WALK_RED;
        end
        PH_GO_NS: begin
          o.road_lamps = ROAD_GO_NS;
          o.walk_lamps = WALK_RED;
        end
        PH_YEL_EW: begin
          o.road_lamps = ROAD_YEL_EW;
          o.walk_lamps = WALK_RED;
        end
        PH_YEL_NS: begin
          o.road_lamps = ROAD_YEL_NS;
          o.walk_lamps = WALK_RED;
        end
        default: begin
          o.road_lamps = ROAD_OFF;
          o.walk_lamps = WALK_OFF;
        end
      endcase
      return o;
    endfunction

    // Successor table, one row per phase, indexed by the detector word.
    function phase_e successor(phase_e ph, logic [2:0] sel);
      phase_e row[8];
      case (ph)
        PH_WALK:   row = '{PH_WALK, PH_WALK, PH_FLASH1, PH_FLASH1,
                           PH_FLASH1, PH_FLASH1, PH_FLASH1, PH_FLASH1};
        PH_FLASH1: row = '{default: PH_FLASH2};
        PH_FLASH2: row = '{default: PH_FLASH3};
        PH_FLASH3: row = '{default: PH_FLASH4};
        PH_FLASH4: row = '{default: PH_FLASH5};
        PH_FLASH5: row = '{PH_WALK, PH_WALK, PH_GO_NS, PH_GO_NS,
                           PH_GO_EW, PH_GO_EW, PH_GO_EW, PH_GO_EW};
        PH_GO_EW:  row = '{PH_YEL_EW, PH_YEL_EW, PH_YEL_EW, PH_YEL_EW,
                           PH_GO_EW, PH_YEL_EW, PH_YEL_EW, PH_YEL_EW};
        PH_GO_NS:  row = '{PH_YEL_NS, PH_YEL_NS, PH_GO_NS, PH_YEL_NS,
                           PH_YEL_NS, PH_YEL_NS, PH_YEL_NS, PH_YEL_NS};
        PH_YEL_EW: row = '{PH_WALK, PH_WALK, PH_GO_NS, PH_GO_NS,
                           PH_GO_EW, PH_WALK, PH_GO_NS, PH_GO_NS};
        PH_YEL_NS: row = '{PH_WALK, PH_WALK, PH_GO_NS, PH_WALK,
                           PH_GO_EW, PH_WALK, PH_GO_EW, PH_WALK};
        default:   row = '{default: PH_WALK};
      endcase
      return row[sel];
    endfunction

    function void note_tick(in_item_t t);
      logic [2:0] sel;
      phase_e     nx;
      sel = {t.ew_car, t.ns_car, t.pedestrian};
      lamps_due.push_back(lamps_for(cur_phase));
      // A dwell of zero behaves as one: the detectors are read on this tick.
      if (ticks_left <= 1) begin
        nx = successor(cur_phase, sel);
        cur_phase = nx;
        if (nx == PH_WALK || nx == PH_GO_EW || nx == PH_GO_NS) begin
          ticks_left = long_dwell;
        end else begin
          ticks_left = short_dwell;
        end
      end else begin
        ticks_left = ticks_left - 1'b1;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_o;
      if (lamps_due.size() == 0) begin
        $display("%0t: result with none expected: got %h", $time, got);
        mismatches++;
        return;
      end
      exp_o = lamps_due.pop_front();
      if (got.road_lamps !== exp_o.road_lamps) begin
        $display("%0t: road_lamps expected %h actual %h", $time, exp_o.road_lamps,
                 got.road_lamps);
        mismatches++;
      end
      if (got.walk_lamps !== exp_o.walk_lamps) begin
        $display("%0t: walk_lamps expected %h actual %h", $time, exp_o.walk_lamps,
                 got.walk_lamps);
        mismatches++;
      end
      if (got.phase !== exp_o.phase) begin
        $display("%0t: phase expected %0d actual %0d", $time, exp_o.phase, got.phase);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return lamps_due.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_item;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_item;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int unsigned     send_idle_pct = 0;
  int unsigned     recv_idle_pct = 0;
  phase_scoreboard sb;

  traffic_light_pedestrian_fsm dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_tick(in_item);
      if (out_valid && !out_stall) sb.check_result(out_item);
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_tick(input in_item_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    drain();
    repeat (DRAIN_SLACK) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_segment(input int unsigned n, input logic [DWELL_W-1:0] long_val,
                             input logic [DWELL_W-1:0] short_val);
    write_reg(REG_LONG_DWELL, long_val);
    write_reg(REG_SHORT_DWELL, short_val);
    for (int i = 0; i < n; i++) begin
      // Hold the sender back once until the block has emptied.
      if (i == n / 2) drain();
      send_tick(in_item_t'(3'($urandom_range(7))));
    end
  endtask

  initial begin
    #200000;
    $display("[traffic_light_pedestrian_fsm] ERROR");
    $finish;
  end

  initial begin
    sb        = new;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_LONG_DWELL;
    cfg_wdata = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 34;
    recv_idle_pct = 73;

    // New dwell values only apply at the next reload, so the first walk still runs the
    // full reset count. A zero short dwell makes the flashing phases one tick each, and
    // writes to the spare indexes must change nothing.
    write_reg(REG_LONG_DWELL, 16'd3);
    write_reg(REG_SHORT_DWELL, 16'd0);
    write_reg(REG_SPARE_LO, 16'hFFFF);
    write_reg(REG_SPARE_HI, 16'h0001);
    for (int i = 0; i < int'(LONG_DWELL_RESET) - 1; i++) send_tick('0);
    for (int i = 0; i < 24; i++) send_tick(in_item_t'(3'(i)));

    run_segment(30, 16'd1, 16'd1);
    run_segment(30, 16'($urandom_range(2, 5)), 16'($urandom_range(1, 3)));
    run_segment(30, 16'($urandom_range(1, 4)), 16'd2);

    send_idle_pct = 73;
    recv_idle_pct = 34;
    run_segment(30, 16'd3, 16'd1);
    run_segment(30, 16'($urandom_range(1, 6)), 16'($urandom_range(1, 3)));
    run_segment(30, 16'hFFFF, 16'hFFFF);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_segment(30, 16'($urandom_range(1, 8)), 16'($urandom_range(1, 4)));
    run_segment(30, 16'd1, 16'd2);
    run_segment(30, 16'($urandom_range(2, 4)), 16'd1);

    drain();
    repeat (10) @(negedge clk);
    if (sb.mismatches == 0) begin
      $display("[traffic_light_pedestrian_fsm] OK");
    end else begin
      $display("[traffic_light_pedestrian_fsm] ERROR");
    end
    $finish;
  end

endmodule
